// ===== sv/frp_pkg.sv =====
// frp_pkg: types and constants shared by the fasta record parser
`default_nettype none

package frp_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int OUT_LEN_BITS    = 32;
    localparam int FIFO_DEPTH      = 4;

    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    typedef enum logic [2:0] {
        MODE_START = 3'd0,
        MODE_ID    = 3'd1,
        MODE_DESC  = 3'd2,
        MODE_SEQ   = 3'd3,
        MODE_SKIP  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        KIND_ID   = 2'd0,
        KIND_DESC = 2'd1,
        KIND_SEQ  = 2'd2,
        KIND_END  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } t_in_req;

    typedef struct packed {
        t_kind                    item_kind;
        logic [7:0]               out_byte;
        logic [OUT_LEN_BITS-1:0]  record_length;
        logic                     record_ok;
        logic                     last;
    } t_out_req;

endpackage

`default_nettype wire

// ===== sv/fasta_record_parser_top.sv =====
// fasta_record_parser_top: byte classifier for fasta text with a small result queue
//
//   channel | valid      | stall       | request
//   --------+------------+-------------+-----------
//   input   | i_in_valid | o_in_stall  | i_in_req
//   output  | o_out_valid| i_out_stall | o_out_req
//
// one input request is taken per cycle while o_in_stall is low; its zero, one or
// two results are written into a four-entry result queue in the same edge and
// leave one per cycle while i_out_stall is low. o_in_stall rises while fewer than
// two queue entries are free, so a held cr (two results from one byte) fits.
// synchronous active-low reset clears parser state and empties the queue.
`default_nettype none

module fasta_record_parser_top
    import frp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_req  i_in_req,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_req      o_out_req
);

    localparam int PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

    t_mode                  r_mode, n_mode;
    logic                   r_in_record, n_in_record;
    logic                   r_held_cr, n_held_cr;
    logic [LENGTH_BITS-1:0] r_seq_count, n_seq_count;
    logic                   r_ended, n_ended;

    t_out_req               r_fifo [FIFO_DEPTH];
    logic [PTR_BITS-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0]    r_count;

    logic                   in_accept, out_accept;
    logic                   emit_a, emit_b;
    t_out_req               res_a, res_b;
    t_out_req               push0, push1;
    logic [1:0]             push_n;

    t_mode                  mode_t;
    logic                   rec_t;
    logic [LENGTH_BITS-1:0] cnt_t;
    logic [7:0]             b;

    function automatic logic [OUT_LEN_BITS-1:0] f_clamp(input logic [LENGTH_BITS-1:0] cnt);
        logic [63:0] ext;
        ext = 64'(cnt);
        if (ext > 64'(32'hFFFF_FFFF)) begin
            f_clamp = '1;
        end else begin
            f_clamp = ext[OUT_LEN_BITS-1:0];
        end
    endfunction

    // one byte of the current line
    function automatic void f_classify(
        input  t_mode                  mode,
        input  logic                   in_rec,
        input  logic [LENGTH_BITS-1:0] cnt,
        input  logic [7:0]             bt,
        output t_mode                  mode_o,
        output logic                   rec_o,
        output logic [LENGTH_BITS-1:0] cnt_o,
        output logic                   emit_o,
        output t_out_req               res_o
    );
        t_mode m;
        mode_o = mode;
        rec_o  = in_rec;
        cnt_o  = cnt;
        emit_o = 1'b0;
        res_o  = '0;
        m      = mode;
        if (mode == MODE_START && bt == CH_GT) begin
            // header closes the open record
            emit_o              = in_rec;
            res_o.item_kind     = KIND_END;
            res_o.record_length = f_clamp(cnt);
            res_o.record_ok     = 1'b1;
            rec_o               = 1'b1;
            cnt_o               = '0;
            mode_o              = MODE_ID;
        end else begin
            if (mode == MODE_START) begin
                m = in_rec ? MODE_SEQ : MODE_SKIP;
            end
            mode_o = m;
            case (m)
                MODE_ID: begin
                    if (bt == CH_SP || bt == CH_TAB) begin
                        mode_o = MODE_DESC;
                    end else begin
                        emit_o          = 1'b1;
                        res_o.item_kind = KIND_ID;
                        res_o.out_byte  = bt;
                    end
                end
                MODE_DESC: begin
                    emit_o          = 1'b1;
                    res_o.item_kind = KIND_DESC;
                    res_o.out_byte  = bt;
                end
                MODE_SEQ: begin
                    emit_o          = 1'b1;
                    res_o.item_kind = KIND_SEQ;
                    res_o.out_byte  = bt;
                    if (cnt != '1) begin
                        cnt_o = cnt + 1'b1;
                    end
                end
                default: begin
                    mode_o = MODE_SKIP;
                end
            endcase
        end
    endfunction

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_accept  = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_count > CNT_BITS'(FIFO_DEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_out_req   = r_fifo[r_rd_ptr];
    assign b           = i_in_req.data_byte;

    always_comb begin
        n_mode      = r_mode;
        n_in_record = r_in_record;
        n_held_cr   = r_held_cr;
        n_seq_count = r_seq_count;
        n_ended     = r_ended;
        emit_a      = 1'b0;
        emit_b      = 1'b0;
        res_a       = '0;
        res_b       = '0;
        mode_t      = r_mode;
        rec_t       = r_in_record;
        cnt_t       = r_seq_count;
        if (in_accept && !r_ended) begin
            if (i_in_req.end_of_input) begin
                n_held_cr           = 1'b0;
                emit_b              = r_in_record;
                res_b.item_kind     = KIND_END;
                res_b.record_length = f_clamp(r_seq_count);
                res_b.record_ok     = (r_seq_count != '0);
                n_in_record         = 1'b0;
                n_ended             = 1'b1;
                n_mode              = MODE_START;
            end else if (r_held_cr && b == CH_LF) begin
                n_held_cr = 1'b0;
                n_mode    = MODE_START;
            end else begin
                if (r_held_cr) begin
                    f_classify(r_mode, r_in_record, r_seq_count, CH_CR,
                               mode_t, rec_t, cnt_t, emit_a, res_a);
                end
                n_mode      = mode_t;
                n_in_record = rec_t;
                n_seq_count = cnt_t;
                n_held_cr   = 1'b0;
                if (b == CH_CR) begin
                    n_held_cr = 1'b1;
                end else if (b == CH_LF) begin
                    n_mode = MODE_START;
                end else begin
                    f_classify(mode_t, rec_t, cnt_t, b,
                               n_mode, n_in_record, n_seq_count, emit_b, res_b);
                end
            end
        end
    end

    // pack the results and mark the final one
    always_comb begin
        push0  = '0;
        push1  = '0;
        push_n = 2'd0;
        if (emit_a && emit_b) begin
            push0       = res_a;
            push1       = res_b;
            push1.last  = 1'b1;
            push_n      = 2'd2;
        end else if (emit_a) begin
            push0       = res_a;
            push0.last  = 1'b1;
            push_n      = 2'd1;
        end else if (emit_b) begin
            push0       = res_b;
            push0.last  = 1'b1;
            push_n      = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_START;
            r_in_record <= 1'b0;
            r_held_cr   <= 1'b0;
            r_seq_count <= '0;
            r_ended     <= 1'b0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
        end else begin
            r_mode      <= n_mode;
            r_in_record <= n_in_record;
            r_held_cr   <= n_held_cr;
            r_seq_count <= n_seq_count;
            r_ended     <= n_ended;
            r_wr_ptr    <= r_wr_ptr + PTR_BITS'(push_n);
            if (out_accept) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_BITS'(push_n) - CNT_BITS'(out_accept);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= push0;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr_ptr + 1'b1] <= push1;
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_fasta_record_parser_top.sv =====
// tb_fasta_record_parser_top: self-checking testbench for the fasta record parser
`timescale 1ns / 100ps

module tb_fasta_record_parser_top
    import frp_pkg::*;
();

    localparam int          LENGTH_BITS  = LENGTH_BITS_DEF;
    localparam longint      LIMIT_CYCLES = 200000;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          PHASE_ITEMS  = 270;
    localparam logic [63:0] COUNT_MAX    = (64'd1 << LENGTH_BITS) - 64'd1;

    localparam logic [7:0] DIRECTED [25] = '{
        "A", CH_CR, CH_LF, CH_LF,
        CH_GT, 8'h00, 8'hFF, CH_TAB, CH_SP, CH_GT,
        CH_CR, CH_CR, CH_LF,
        CH_CR, "G", CH_LF,
        CH_GT, CH_LF, CH_GT, "x",
        CH_CR, CH_LF, CH_CR, CH_GT, CH_LF
    };

    class parse_checker;
        t_mode           mode;
        bit              in_record;
        bit              held_cr;
        bit              ended;
        longint unsigned seq_count;
        t_out_req        expected_items[$];
        int              errors;

        function new();
            mode      = MODE_START;
            in_record = 0;
            held_cr   = 0;
            ended     = 0;
            seq_count = 0;
            errors    = 0;
        endfunction

        function void push_result(t_kind kind, logic [7:0] b, longint unsigned len, bit ok);
            t_out_req r;
            r.item_kind     = kind;
            r.out_byte      = b;
            r.record_length = (len > 64'hFFFF_FFFF) ? '1 : len[31:0];
            r.record_ok     = ok;
            r.last          = 1'b0;
            expected_items.insert(expected_items.size(), r);
        endfunction

        function void classify_byte(logic [7:0] b);
            if (mode == MODE_START) begin
                if (b == CH_GT) begin
                    if (in_record)
                        push_result(KIND_END, 8'h00, seq_count, 1'b1);
                    in_record = 1;
                    seq_count = 0;
                    mode      = MODE_ID;
                    return;
                end
                mode = in_record ? MODE_SEQ : MODE_SKIP;
            end
            case (mode)
                MODE_ID: begin
                    if (b == CH_SP || b == CH_TAB)
                        mode = MODE_DESC;
                    else
                        push_result(KIND_ID, b, 0, 1'b0);
                end
                MODE_DESC: push_result(KIND_DESC, b, 0, 1'b0);
                MODE_SEQ: begin
                    push_result(KIND_SEQ, b, 0, 1'b0);
                    if (seq_count < COUNT_MAX)
                        seq_count++;
                end
                default: ;
            endcase
        endfunction

        function void note_input(t_in_req req);
            int prior_size;
            prior_size = expected_items.size();
            if (ended)
                return;
            if (req.end_of_input) begin
                held_cr = 0;
                if (in_record)
                    push_result(KIND_END, 8'h00, seq_count, seq_count != 0);
                in_record = 0;
                ended     = 1;
                mode      = MODE_START;
            end else begin
                if (held_cr) begin
                    held_cr = 0;
                    if (req.data_byte == CH_LF) begin
                        mode = MODE_START;
                        return;
                    end
                    classify_byte(CH_CR);
                end
                if (req.data_byte == CH_CR)
                    held_cr = 1;
                else if (req.data_byte == CH_LF)
                    mode = MODE_START;
                else
                    classify_byte(req.data_byte);
            end
            if (expected_items.size() > prior_size)
                expected_items[expected_items.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_output(t_out_req got);
            t_out_req want;
            if (expected_items.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %p", $time, got);
                return;
            end
            want = expected_items.pop_front();
            compare_field("item_kind", 32'(want.item_kind), 32'(got.item_kind));
            compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
            compare_field("record_length", want.record_length, got.record_length);
            compare_field("record_ok", 32'(want.record_ok), 32'(got.record_ok));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     i_out_stall = 1'b0;
    t_in_req  i_in_req    = '0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_req o_out_req;

    parse_checker sb = new();
    int           in_idle_pct  = 24;
    int           out_idle_pct = 84;
    int           items_sent   = 0;
    longint       cycle_count  = 0;
    string        seq_alphabet = "ACGTNacgtn";

    fasta_record_parser_top #(.LENGTH_BITS(LENGTH_BITS)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("fasta_record_parser_top regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid !== 1'b0 && !i_out_stall)
            sb.check_output(o_out_req);
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    task automatic send_req(t_in_req req);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do
            @(posedge i_clk);
        while (o_in_stall);
        sb.note_input(req);
        items_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        t_in_req req;
        req.data_byte    = b;
        req.end_of_input = 1'b0;
        send_req(req);
    endtask

    task automatic send_end();
        t_in_req req;
        req.data_byte    = 8'($urandom_range(255));
        req.end_of_input = 1'b1;
        send_req(req);
    endtask

    function automatic logic [7:0] text_byte(bit no_blank);
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_LF || b == CH_CR || (no_blank && (b == CH_SP || b == CH_TAB)));
        return b;
    endfunction

    task automatic send_line_end();
        if ($urandom_range(3) == 0)
            send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_record();
        int n_id;
        int n_desc;
        int n_lines;
        int n_seq;
        n_id    = $urandom_range(6);
        n_desc  = $urandom_range(8);
        n_lines = $urandom_range(3);
        send_byte(CH_GT);
        repeat (n_id) send_byte(text_byte(1));
        if ($urandom_range(1)) begin
            send_byte($urandom_range(1) ? CH_SP : CH_TAB);
            repeat (n_desc) send_byte(text_byte(0));
        end
        send_line_end();
        repeat (n_lines) begin
            if ($urandom_range(7) == 0) begin
                send_line_end();
            end else begin
                n_seq = $urandom_range(1, 12);
                repeat (n_seq) begin
                    // stray cr inside a line
                    if ($urandom_range(19) == 0)
                        send_byte(CH_CR);
                    else
                        send_byte(seq_alphabet[$urandom_range(9)]);
                end
                send_line_end();
            end
        end
    endtask

    task automatic run_random(int target);
        while (items_sent < target) begin
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
            else
                send_record();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) send_byte(DIRECTED[i]);

        run_random(items_sent + PHASE_ITEMS);
        in_idle_pct  = 84;
        out_idle_pct = 24;
        run_random(items_sent + PHASE_ITEMS);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_random(items_sent + PHASE_ITEMS);

        // closing record, empty or not, with a cr left hanging at random
        send_byte(CH_GT);
        send_byte("e");
        if ($urandom_range(1)) begin
            send_byte(CH_LF);
            send_byte("A");
        end
        if ($urandom_range(1))
            send_byte(CH_CR);
        send_end();

        // requests after end of input are ignored
        repeat (3) send_byte(8'($urandom_range(255)));
        send_end();
        i_in_valid <= 1'b0;

        while (sb.expected_items.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.expected_items.size() != 0)
            $display("%0t: %0d expected results never arrived", $time,
                     sb.expected_items.size());
        if (sb.errors == 0 && sb.expected_items.size() == 0)
            $display("fasta_record_parser_top regression: pass");
        else
            $display("fasta_record_parser_top regression: fail");
        $finish;
    end

endmodule
